@@ hw/rtl/mbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg
// shared types, constants and helpers of the stride-3 multibit trie lookup
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int STRIDE         = 3;
    localparam int SLOTS_PER_NODE = 8;
    localparam int NODE_COUNT     = 1024;
    localparam int LEVELS         = 11;
    localparam int ADDR_BITS      = 32;

    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int SLOT_AW    = NODE_AW + $clog2(SLOTS_PER_NODE);
    localparam int SLOT_COUNT = NODE_COUNT * SLOTS_PER_NODE;
    localparam int USED_W     = NODE_AW + 1;

    localparam logic [3:0] LAST_LEVEL = 4'(LEVELS - 1);
    localparam logic [5:0] MAX_PLEN   = 6'(ADDR_BITS);

    // one slot of a trie node
    typedef struct packed {
        logic [7:0]         port;
        logic [1:0]         len;
        logic [NODE_AW-1:0] child;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WALK,
        S_EXP
    } t_state;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_NODE  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    // 3-bit chunk at a level, address padded with one zero bit on the right
    function automatic logic [2:0] chunk_at(input logic [31:0] addr, input logic [3:0] level);
        logic [32:0] padded;
        logic [4:0]  sh;
        padded = {addr, 1'b0};
        sh     = 5'd30 - ({level, 1'b0} + {1'b0, level});
        return padded[sh +: 3];
    endfunction

    // number of full strides for a clamped prefix length 1..32: (p-1)/3
    function automatic logic [3:0] full_of(input logic [5:0] plen);
        logic [4:0] pm1;
        logic [8:0] prod;
        pm1  = 5'(plen - 6'd1);
        prod = {4'b0, pm1} * 9'd11;
        return prod[8:5];
    endfunction

    // prefix bits used in the last stride, 1..3
    function automatic logic [1:0] local_of(input logic [5:0] plen, input logic [3:0] full);
        logic [5:0] used;
        used = {1'b0, full, 1'b0} + {2'b0, full};
        return 2'(plen - used);
    endfunction

    // slot mask of the expanded range
    function automatic logic [2:0] exp_mask(input logic [1:0] loc);
        logic [2:0] m;
        case (loc)
            2'd1:    m = 3'b100;
            2'd2:    m = 3'b110;
            default: m = 3'b111;
        endcase
        return m;
    endfunction

    // index of the last expanded slot
    function automatic logic [1:0] exp_last(input logic [1:0] loc);
        logic [1:0] l;
        case (loc)
            2'd1:    l = 2'd3;
            2'd2:    l = 2'd1;
            default: l = 2'd0;
        endcase
        return l;
    endfunction

endpackage

@@ hw/rtl/mbt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/multibit_trie_route_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup
// ipv4 longest-prefix-match engine on a stride-3 multibit trie in one node ram
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with o_valid high, and it cannot be held
// off. After reset the node ram is cleared one slot per cycle, all 8192 slots
// (NODE_COUNT * 8), with busy high. The node ram gives one slot read per cycle
// and the walk advances one trie level per read: a lookup visits L levels
// (1..11). An insert walks F = (len-1)/3 full strides (0..10), ending early
// with no-node status if the node pool runs out, then visits the 1, 2 or 4
// slots of the last stride; a zero-length insert stores nothing. The result
// appears the cycle after the last step.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup
    import mbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_dest_addr,
    input  logic [5:0]  i_prefix_len,
    input  logic [7:0]  i_route_port,
    output logic        o_valid,
    output logic [7:0]  o_fwd_port,
    output logic [1:0]  o_status
);

    // state and control
    t_state              r_state, n_state;
    logic [SLOT_AW-1:0]  r_clr, n_clr;
    logic [USED_W-1:0]   r_nodes_used, n_nodes_used;
    logic                r_valid, n_valid;

    // transaction context
    logic [31:0]         r_addr, n_addr;
    logic [3:0]          r_full, n_full;
    logic [1:0]          r_local, n_local;
    logic [7:0]          r_port, n_port;
    logic [3:0]          r_level, n_level;
    logic [NODE_AW-1:0]  r_node, n_node;
    logic [1:0]          r_k, n_k;
    logic [SLOT_AW-1:0]  r_raddr;
    logic [7:0]          r_fwd, n_fwd;
    logic [1:0]          r_status, n_status;

    // ram port
    logic                we;
    logic [SLOT_AW-1:0]  wr_addr;
    t_slot               wr_data;
    logic [NODE_AW-1:0]  rd_node;
    logic [2:0]          rd_slot;
    logic [SLOT_AW-1:0]  rd_addr;
    logic [SLOT_W-1:0]   rd_raw;
    t_slot               rslot;

    // decode of the incoming transaction
    logic                accept;
    logic [5:0]          in_plen;
    logic [3:0]          in_full;
    logic [1:0]          in_local;
    logic [2:0]          in_chunk0;

    // walk decisions
    logic                clr_last;
    logic                lk_stop;
    logic                no_child;
    logic                pool_empty;
    logic                walk_to_exp;
    logic                exp_end;
    logic [3:0]          level_nx;
    logic [2:0]          chunk_nx;
    logic [2:0]          exp_base;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign rd_addr = {rd_node, rd_slot};
    assign rslot   = t_slot'(rd_raw);

    always_comb begin
        in_plen   = (i_prefix_len > MAX_PLEN) ? MAX_PLEN : i_prefix_len;
        in_full   = full_of(in_plen);
        in_local  = local_of(in_plen, in_full);
        in_chunk0 = chunk_at(i_dest_addr, 4'd0);

        clr_last    = (r_clr == SLOT_AW'(SLOT_COUNT - 1));
        level_nx    = r_level + 4'd1;
        chunk_nx    = chunk_at(r_addr, level_nx);
        exp_base    = chunk_at(r_addr, r_full) & exp_mask(r_local);
        no_child    = (rslot.child == '0);
        lk_stop     = no_child || (r_level == LAST_LEVEL);
        pool_empty  = (r_nodes_used >= USED_W'(NODE_COUNT));
        walk_to_exp = (level_nx == r_full);
        exp_end     = (r_k == exp_last(r_local));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_LOOKUP) begin
                        n_state = S_LOOK;
                    end else if (in_plen == 6'd0) begin
                        n_state = S_IDLE;
                    end else if (in_full == 4'd0) begin
                        n_state = S_EXP;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_LOOK: begin
                if (lk_stop) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (no_child && pool_empty) begin
                    n_state = S_IDLE;
                end else if (walk_to_exp) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (exp_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, ram control and results
    always_comb begin
        n_clr        = r_clr;
        n_nodes_used = r_nodes_used;
        n_valid      = 1'b0;
        n_addr       = r_addr;
        n_full       = r_full;
        n_local      = r_local;
        n_port       = r_port;
        n_level      = r_level;
        n_node       = r_node;
        n_k          = r_k;
        n_fwd        = r_fwd;
        n_status     = r_status;
        we           = 1'b0;
        wr_addr      = r_raddr;
        wr_data      = rslot;
        rd_node      = '0;
        rd_slot      = '0;

        case (r_state)
            S_CLEAR: begin
                we      = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + SLOT_AW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_addr  = i_dest_addr;
                    n_full  = in_full;
                    n_local = in_local;
                    n_level = 4'd0;
                    n_node  = '0;
                    n_k     = 2'd0;
                    rd_node = '0;
                    if (i_func == FUNC_LOOKUP) begin
                        n_port  = 8'd0;
                        rd_slot = in_chunk0;
                    end else begin
                        n_port = i_route_port;
                        if (in_full == 4'd0) begin
                            rd_slot = in_chunk0 & exp_mask(in_local);
                        end else begin
                            rd_slot = in_chunk0;
                        end
                        if (in_plen == 6'd0) begin
                            // zero-length route: nothing stored
                            n_valid  = 1'b1;
                            n_fwd    = 8'd0;
                            n_status = STATUS_ZERO_LEN;
                        end
                    end
                end
            end
            S_LOOK: begin
                // keep the last nonzero port met along the walk
                if (rslot.port != 8'd0) begin
                    n_port = rslot.port;
                end
                if (lk_stop) begin
                    n_valid  = 1'b1;
                    n_fwd    = (rslot.port != 8'd0) ? rslot.port : r_port;
                    n_status = STATUS_DONE;
                end else begin
                    n_level = level_nx;
                    n_node  = rslot.child;
                    rd_node = rslot.child;
                    rd_slot = chunk_nx;
                end
            end
            S_WALK: begin
                if (no_child && pool_empty) begin
                    n_valid  = 1'b1;
                    n_fwd    = 8'd0;
                    n_status = STATUS_NO_NODE;
                end else begin
                    if (no_child) begin
                        // link a fresh node, port and length of the slot kept
                        we            = 1'b1;
                        wr_data.child = r_nodes_used[NODE_AW-1:0];
                        n_nodes_used  = r_nodes_used + USED_W'(1);
                        rd_node       = r_nodes_used[NODE_AW-1:0];
                    end else begin
                        rd_node = rslot.child;
                    end
                    n_node  = rd_node;
                    n_level = level_nx;
                    n_k     = 2'd0;
                    rd_slot = walk_to_exp ? (chunk_nx & exp_mask(r_local)) : chunk_nx;
                end
            end
            S_EXP: begin
                // longer or equal local length wins the slot
                if (r_local >= rslot.len) begin
                    we           = 1'b1;
                    wr_data.port = r_port;
                    wr_data.len  = r_local;
                end
                if (exp_end) begin
                    n_valid  = 1'b1;
                    n_fwd    = 8'd0;
                    n_status = STATUS_DONE;
                end else begin
                    n_k     = r_k + 2'd1;
                    rd_node = r_node;
                    rd_slot = exp_base | {1'b0, n_k};
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_nodes_used <= USED_W'(1);
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_nodes_used <= n_nodes_used;
            r_valid      <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_full   <= n_full;
        r_local  <= n_local;
        r_port   <= n_port;
        r_level  <= n_level;
        r_node   <= n_node;
        r_k      <= n_k;
        r_raddr  <= rd_addr;
        r_fwd    <= n_fwd;
        r_status <= n_status;
    end

    // slot store: port, local length and child per slot
    mbt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    assign o_valid    = r_valid;
    assign o_fwd_port = r_fwd;
    assign o_status   = r_status;

`ifndef SYNTHESIS
    // every accepted transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_valid || busy))
        else $error("accepted transaction neither answered nor busy");

    // node pool count stays within root and pool size
    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used >= USED_W'(1)) && (r_nodes_used <= USED_W'(NODE_COUNT)))
        else $error("node pool count out of range");

    // nodes are only allocated during an insert walk
    a_pool_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |=> $stable(r_nodes_used))
        else $error("node pool changed outside insert walk");

    // a lookup never writes the slot store
    a_lookup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> !we)
        else $error("slot write during lookup");

    // a matched port only comes with a done status
    a_port_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_fwd_port != 8'd0)) |-> (o_status == STATUS_DONE))
        else $error("port reported with error status");
`endif

endmodule

@@ tb/tb_multibit_trie_route_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multibit_trie_route_lookup
// self-checking bench for the stride-3 multibit trie route lookup engine
// ----------------------------------------------------------------------------
// A queue of route inserts and address lookups is filled up front. A clocked
// driver presents it on the start/busy handshake with random idle bursts. It
// runs every accepted transaction through a bench-side trie, which holds the
// slot ports, local lengths, child links and the node pool count. The
// expected answers are queued, and a clocked monitor compares each strobed
// result with the oldest one. A watchdog ends the run when nothing moves.
// ----------------------------------------------------------------------------
module tb_multibit_trie_route_lookup
    import mbt_pkg::*;
();

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1780;
    localparam int NO_IDLE_TAIL   = 200;
    localparam int DRAIN_CYCLES   = 30;
    // several times the ram clear of all 8192 slots after reset plus one full walk
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int FAMILY_COUNT   = 16;

    typedef struct {
        logic        op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [7:0]  port;
    } t_route_req;

    typedef struct {
        logic [7:0] fwd_port;
        logic [1:0] status;
    } t_route_ans;

    // dut ports, inputs known from time zero
    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic        i_func       = FUNC_INSERT;
    logic [31:0] i_dest_addr  = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [7:0]  i_route_port = '0;
    logic        o_valid;
    logic [7:0]  o_fwd_port;
    logic [1:0]  o_status;

    // bench-side trie
    bit [7:0]    trie_port  [SLOT_COUNT];
    bit [1:0]    trie_len   [SLOT_COUNT];
    int          trie_child [SLOT_COUNT];
    int          trie_nodes_used = 1;

    t_route_req  route_req_q[$];
    t_route_ans  answer_q[$];
    logic [31:0] family_base[FAMILY_COUNT];

    t_route_req  drv_item;
    int          gap_left    = 0;
    int          idle_pct    = 0;
    int          accept_cnt  = 0;
    int          fail_cnt    = 0;
    int          quiet_cycles = 0;
    t_route_ans  mon_want;

    multibit_trie_route_lookup u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_dest_addr  (i_dest_addr),
        .i_prefix_len (i_prefix_len),
        .i_route_port (i_route_port),
        .o_valid      (o_valid),
        .o_fwd_port   (o_fwd_port),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // trie predictor
    // ------------------------------------------------------------------------

    // 3-bit chunk of the address at a level, one zero bit padded on the right
    function automatic int trie_chunk(logic [31:0] addr, int lv);
        logic [32:0] padded;
        padded = {addr, 1'b0};
        return int'((padded >> (STRIDE * (LEVELS - 1) - STRIDE * lv)) & 33'd7);
    endfunction

    // walk along the destination, keep the last nonzero port met
    function automatic logic [7:0] trie_lookup(logic [31:0] addr);
        int         node;
        int         idx;
        bit         stop;
        logic [7:0] fwd;
        node = 0;
        stop = 1'b0;
        fwd  = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (!stop) begin
                idx = node * SLOTS_PER_NODE + trie_chunk(addr, lv);
                if (trie_port[idx] != 8'd0)
                    fwd = trie_port[idx];
                if (trie_child[idx] == 0)
                    stop = 1'b1;
                else
                    node = trie_child[idx];
            end
        end
        return fwd;
    endfunction

    // walk and allocate full strides, then expand the last one
    function automatic logic [1:0] trie_insert(logic [31:0] addr, logic [5:0] plen_in,
                                               logic [7:0] port);
        int plen;
        int full;
        int loc;
        int span;
        int base;
        int node;
        int idx;
        int child;
        if (plen_in == 6'd0)
            return STATUS_ZERO_LEN;
        plen = (plen_in > MAX_PLEN) ? ADDR_BITS : int'(plen_in);
        full = (plen - 1) / STRIDE;
        loc  = plen - STRIDE * full;
        node = 0;
        for (int lv = 0; lv < full; lv++) begin
            idx   = node * SLOTS_PER_NODE + trie_chunk(addr, lv);
            child = trie_child[idx];
            if (child == 0) begin
                // pool exhausted: nodes linked so far stay, no port written
                if (trie_nodes_used >= NODE_COUNT)
                    return STATUS_NO_NODE;
                child = trie_nodes_used;
                trie_nodes_used++;
                trie_child[idx] = child;
            end
            node = child;
        end
        span = 1 << (STRIDE - loc);
        base = trie_chunk(addr, full) & ~(span - 1);
        for (int k = 0; k < span; k++) begin
            idx = node * SLOTS_PER_NODE + ((base + k) & 7);
            // longer or equal local length wins the expanded slot
            if (loc >= int'(trie_len[idx])) begin
                trie_len[idx]  = 2'(loc);
                trie_port[idx] = port;
            end
        end
        return STATUS_DONE;
    endfunction

    function automatic t_route_ans trie_apply(t_route_req rq);
        t_route_ans a;
        a.fwd_port = '0;
        a.status   = STATUS_DONE;
        if (rq.op == FUNC_LOOKUP)
            a.fwd_port = trie_lookup(rq.addr);
        else
            a.status = trie_insert(rq.addr, rq.plen, rq.port);
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_req(logic op, logic [31:0] addr, logic [5:0] plen, logic [7:0] port);
        t_route_req rq;
        rq.op   = op;
        rq.addr = addr;
        rq.plen = plen;
        rq.port = port;
        route_req_q.insert(route_req_q.size(), rq);
    endtask

    // address near one of a few route families, so walks share nodes
    function automatic logic [31:0] near_family();
        logic [31:0] mask;
        int          keep_low;
        keep_low = $urandom_range(0, 32);
        mask     = (32'h1 << keep_low) - 32'h1;
        if (keep_low == 32)
            mask = 32'hFFFF_FFFF;
        return family_base[$urandom_range(0, FAMILY_COUNT - 1)] ^ ($urandom & mask);
    endfunction

    // mostly legal lengths, some zero and some above 32
    function automatic logic [5:0] pick_prefix_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 6'd0;
        else if (r < 6)
            return 6'($urandom_range(33, 63));
        else if (r < 40)
            return 6'($urandom_range(1, 12));
        else
            return 6'($urandom_range(13, 32));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int r;

        for (int f = 0; f < FAMILY_COUNT; f++)
            family_base[f] = $urandom;

        // directed: empty table, zero length, 4/2/1-slot expansion,
        // shorter route next to longer ones, full and clamped lengths,
        // port zero route, address extremes
        queue_req(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'd0);
        queue_req(FUNC_INSERT, 32'h0000_0000, 6'd0,  8'd5);
        queue_req(FUNC_INSERT, 32'hA000_0000, 6'd1,  8'd11);
        queue_req(FUNC_INSERT, 32'hC000_0000, 6'd2,  8'd22);
        queue_req(FUNC_INSERT, 32'hE000_0000, 6'd3,  8'd33);
        queue_req(FUNC_INSERT, 32'h8000_0000, 6'd1,  8'd44);
        queue_req(FUNC_LOOKUP, 32'h8000_0000, 6'd63, 8'hFF);
        queue_req(FUNC_LOOKUP, 32'hC123_4567, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'd0);
        queue_req(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd255);
        queue_req(FUNC_INSERT, 32'h1234_5678, 6'd63, 8'h5A);
        queue_req(FUNC_INSERT, 32'h1234_5678, 6'd31, 8'd0);
        queue_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'h1234_5678, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'h1234_5679, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'h1234_567A, 6'd0,  8'd0);
        queue_req(FUNC_INSERT, 32'h5555_5555, 6'd30, 8'h81);
        queue_req(FUNC_INSERT, 32'hAAAA_AAAA, 6'd16, 8'h7E);
        queue_req(FUNC_LOOKUP, 32'h5555_5557, 6'd0,  8'd0);
        queue_req(FUNC_LOOKUP, 32'hAAAA_FFFF, 6'd0,  8'd0);
        queue_req(FUNC_INSERT, 32'h0000_0000, 6'd32, 8'd1);
        queue_req(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'd0);

        // random: mostly family routes and lookups, some scattered long
        // routes that drain the node pool
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 44)
                queue_req(FUNC_INSERT, near_family(), pick_prefix_len(),
                          8'($urandom_range(0, 255)));
            else if (r < 50)
                queue_req(FUNC_INSERT, $urandom, 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            else if (r < 94)
                queue_req(FUNC_LOOKUP, near_family(), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            else
                queue_req(FUNC_LOOKUP, $urandom, 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all transactions taken and all answers back
        while (route_req_q.size() != 0 || start || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: one item held on the ports until the handshake takes it
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                // transaction taken at this edge, predict its answer now
                answer_q.insert(answer_q.size(), trie_apply(drv_item));
                accept_cnt++;
                // switch idle behavior every so often, some phases never idle
                if (accept_cnt % 150 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 25;
                        default: idle_pct = 60;
                    endcase
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (route_req_q.size() == 0) begin
                    start <= 1'b0;
                end else if (route_req_q.size() > NO_IDLE_TAIL &&
                             $urandom_range(0, 99) < idle_pct) begin
                    // idle burst: this cycle plus gap_left further idle cycles
                    gap_left = $urandom_range(0, 10);
                    start <= 1'b0;
                end else begin
                    drv_item = route_req_q[0];
                    route_req_q.delete(0);
                    start        <= 1'b1;
                    i_func       <= drv_item.op;
                    i_dest_addr  <= drv_item.addr;
                    i_prefix_len <= drv_item.plen;
                    i_route_port <= drv_item.port;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each strobed result against the oldest expected answer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                fail_cnt++;
                $display("%0t unexpected result: expected none actual fwd_port %0d status %0d",
                         $time, o_fwd_port, o_status);
            end else begin
                mon_want = answer_q[0];
                answer_q.delete(0);
                if (o_fwd_port !== mon_want.fwd_port) begin
                    fail_cnt++;
                    $display("%0t fwd_port mismatch: expected %0d actual %0d",
                             $time, mon_want.fwd_port, o_fwd_port);
                end
                if (o_status !== mon_want.status) begin
                    fail_cnt++;
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, mon_want.status, o_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with neither a transaction nor a result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_rst_n && o_valid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog timeout after %0d idle cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

@@ sim.f @@
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_ram.sv
hw/rtl/multibit_trie_route_lookup.sv
tb/tb_multibit_trie_route_lookup.sv
